// ===== sv/skl_pkg.sv =====
package skl_pkg;

  localparam int unsigned DEPTH         = 16;
  localparam int unsigned PAYLOAD_WIDTH = 32;
  localparam int unsigned KEY_WIDTH     = 64;
  localparam int unsigned CNT_WIDTH     = $clog2(DEPTH + 1);
  localparam int unsigned CAP_WIDTH     = 5;
  localparam int unsigned FUNC_WIDTH    = 2;
  localparam int unsigned STATUS_WIDTH  = 2;
  localparam int unsigned IO_PAY_WIDTH  = 32;

  // operation codes on the request side
  localparam logic [FUNC_WIDTH-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_WIDTH-1:0] FUNC_UPDATE = 2'd2;

  // result status codes
  localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] STATUS_NOTFOUND = 2'd3;

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

  typedef logic [KEY_WIDTH-1:0]     key_t;
  typedef logic [PAYLOAD_WIDTH-1:0] pay_t;
  typedef logic [CNT_WIDTH-1:0]     cnt_t;

  // command broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_REM
  } op_e;

  typedef struct packed {
    op_e  op;
    key_t key;
    pay_t pay;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_REINS
  } state_e;

endpackage

// ===== sv/sorted_key_list_unit.sv =====
// Sorted key list: holds up to DEPTH (64-bit key, payload) entries in
// ascending key order, equal keys in arrival order, in a row of cells that
// each hold one entry and shift it to a neighbor when an entry enters or
// leaves. Each request on the slave stream (func in tuser) gives exactly one
// result on the master stream. Insert, remove and the no-op code take one
// pass in the cell row; update takes two, a remove pass and a reinsert pass,
// so a new request is accepted every cycle for insert/remove (given the
// result is taken), but not during a reinsert pass. The result sits in an
// output register; the next request is taken in the same cycle that register
// is emptied. Capacity has its own channel, always ready; the user must write
// it only while the block is idle (not enforced). Values above DEPTH act as
// DEPTH, and lowering it below the count keeps the entries. No clearing pass
// is needed after reset: only cells below the count are ever looked at.
module sorted_key_list_unit import skl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: key[63:0], new_key[127:64], payload[159:128], zero fill[167:160]
  input  logic [167:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], payload_out[33:2], count[38:34], zero fill[39]
  output logic [39:0]  m_axis_tdata,
  // capacity write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i
);

  // request fields
  logic [FUNC_WIDTH-1:0] in_func;
  key_t                  in_key, in_new_key;
  pay_t                  in_pay;

  assign in_func    = s_axis_tuser;
  assign in_key     = s_axis_tdata[63:0];
  assign in_new_key = s_axis_tdata[127:64];
  assign in_pay     = pay_t'(s_axis_tdata[159:128]);

  // control state
  state_e                 state_q, state_d;
  cnt_t                   count_q, count_d;
  logic [CAP_WIDTH-1:0]   cap_q;
  logic                   ovalid_q, ovalid_d;

  // result register (status and payload)
  logic [STATUS_WIDTH-1:0] status_q, status_d;
  pay_t                    pout_q, pout_d;

  // held for the reinsert pass of an update
  key_t upd_key_q, upd_key_d;
  pay_t upd_pay_q, upd_pay_d;

  cmd_t cmd;
  logic found;
  pay_t found_pay;
  logic accept, full, out_free;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // capacity above DEPTH behaves as DEPTH; count never passes DEPTH
  assign full = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= DEPTH);

  skl_chain u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .count_i (count_q),
    .found_o (found),
    .pay_o   (found_pay)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_func == FUNC_UPDATE && count_q != '0 && found) begin
          state_d = ST_REINS;
        end
      end
      ST_REINS: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and result control
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.key   = in_key;
    cmd.pay   = in_pay;
    count_d   = count_q;
    status_d  = status_q;
    pout_d    = pout_q;
    upd_key_d = upd_key_q;
    upd_pay_d = upd_pay_q;
    ovalid_d  = ovalid_q && !m_axis_tready;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ovalid_d = 1'b1;
          status_d = STATUS_OK;
          pout_d   = '0;
          priority if (in_func == FUNC_INSERT) begin
            if (full) begin
              status_d = STATUS_FULL;
            end else begin
              cmd.op  = OP_INS;
              count_d = count_q + cnt_t'(1);
            end
          end else if (in_func == FUNC_REMOVE || in_func == FUNC_UPDATE) begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
            end else if (!found) begin
              status_d = STATUS_NOTFOUND;
            end else begin
              cmd.op  = OP_REM;
              count_d = count_q - cnt_t'(1);
              pout_d  = found_pay;
              if (in_func == FUNC_UPDATE) begin
                // result waits for the reinsert pass
                ovalid_d  = 1'b0;
                upd_key_d = in_new_key;
                upd_pay_d = found_pay;
              end
            end
          end else begin
            // unused code: no operation
          end
        end
      end
      ST_REINS: begin
        // own slot was just freed: no capacity check
        cmd.op   = OP_INS;
        cmd.key  = upd_key_q;
        cmd.pay  = upd_pay_q;
        count_d  = count_q + cnt_t'(1);
        ovalid_d = 1'b1;
        status_d = STATUS_OK;
        pout_d   = upd_pay_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cap_q    <= CAP_RESET;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    pout_q    <= pout_d;
    upd_key_q <= upd_key_d;
    upd_pay_q <= upd_pay_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, CAP_WIDTH'(count_q), IO_PAY_WIDTH'(pout_q), status_q};

endmodule

// ===== sv/skl_cell.sv =====
module skl_cell import skl_pkg::*; (
  input  logic clk_i,
  input  cmd_t cmd_i,
  input  logic occ_i,      // this cell holds a live entry
  input  key_t left_key_i,
  input  pay_t left_pay_i,
  input  logic left_le_i,  // left neighbor keeps its entry on insert
  input  key_t right_key_i,
  input  pay_t right_pay_i,
  input  logic seen_i,     // a match lies to the left
  input  pay_t acc_pay_i,  // payload of the first match so far
  output key_t key_o,
  output pay_t pay_o,
  output logic le_o,
  output logic seen_o,
  output pay_t acc_pay_o
);

  key_t key_q, key_d;
  pay_t pay_q, pay_d;
  logic match;

  assign le_o      = occ_i && (key_q <= cmd_i.key);
  assign match     = occ_i && (key_q == cmd_i.key);
  assign seen_o    = seen_i || match;
  assign acc_pay_o = (match && !seen_i) ? pay_q : acc_pay_i;
  assign key_o     = key_q;
  assign pay_o     = pay_q;

  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    unique case (cmd_i.op)
      OP_INS: begin
        if (!le_o) begin
          if (left_le_i) begin
            key_d = cmd_i.key;
            pay_d = cmd_i.pay;
          end else begin
            key_d = left_key_i;
            pay_d = left_pay_i;
          end
        end
      end
      OP_REM: begin
        if (seen_o) begin
          key_d = right_key_i;
          pay_d = right_pay_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
  end

endmodule

// ===== sv/skl_chain.sv =====
module skl_chain import skl_pkg::*; (
  input  logic clk_i,
  input  cmd_t cmd_i,
  input  cnt_t count_i,
  output logic found_o,
  output pay_t pay_o
);

  key_t key_w  [DEPTH];
  pay_t pay_w  [DEPTH];
  logic le_w   [DEPTH];
  logic seen_w [DEPTH];
  pay_t acc_w  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic occ;
    key_t lk, rk;
    pay_t lp, rp, acc_in;
    logic lle, seen_in;

    assign occ = cnt_t'(i) < count_i;

    if (i == 0) begin : g_head
      // a virtual cell in front of the head always keeps its place
      assign lk      = key_w[i];
      assign lp      = pay_w[i];
      assign lle     = 1'b1;
      assign seen_in = 1'b0;
      assign acc_in  = '0;
    end else begin : g_body
      assign lk      = key_w[i-1];
      assign lp      = pay_w[i-1];
      assign lle     = le_w[i-1];
      assign seen_in = seen_w[i-1];
      assign acc_in  = acc_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign rk = key_w[i];
      assign rp = pay_w[i];
    end else begin : g_mid
      assign rk = key_w[i+1];
      assign rp = pay_w[i+1];
    end

    skl_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .occ_i       (occ),
      .left_key_i  (lk),
      .left_pay_i  (lp),
      .left_le_i   (lle),
      .right_key_i (rk),
      .right_pay_i (rp),
      .seen_i      (seen_in),
      .acc_pay_i   (acc_in),
      .key_o       (key_w[i]),
      .pay_o       (pay_w[i]),
      .le_o        (le_w[i]),
      .seen_o      (seen_w[i]),
      .acc_pay_o   (acc_w[i])
    );
  end

  assign found_o = seen_w[DEPTH-1];
  assign pay_o   = acc_w[DEPTH-1];

endmodule

// ===== sv/skl_checker.sv =====
module skl_props import skl_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [39:0]  m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // count never exceeds the row length
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> 32'(m_axis_tdata[38:34]) <= DEPTH)
    else $error("count above depth");

  // errors return no payload
  a_err_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != STATUS_OK |-> m_axis_tdata[33:2] == '0)
    else $error("payload on error result");

  // empty status only with an empty list
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == STATUS_EMPTY |-> m_axis_tdata[38:34] == '0)
    else $error("empty status with entries held");

  // no request is taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request accepted over a stalled result");

endmodule

bind sorted_key_list_unit skl_props u_skl_props (.*);

// ===== verif/skl_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and capacity channels of the sorted key list,
// keeps its own copy of the list and flags every result that differs.
module skl_checker import skl_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // tdata: key[63:0], new_key[127:64], payload[159:128], zero fill[167:160]
  input  logic [167:0] s_axis_tdata,
  // tuser: func[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], payload_out[33:2], count[38:34], zero fill[39]
  input  logic [39:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i,
  output int           mismatch_cnt_o,
  output int           pending_o
);

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [IO_PAY_WIDTH-1:0] pay;
    logic [4:0]              count;
  } outcome_t;

  key_t                 list_key [DEPTH];
  pay_t                 list_pay [DEPTH];
  int unsigned          list_len;
  logic [CAP_WIDTH-1:0] cap_q;
  outcome_t             awaited [$];

  // first match from the head, -1 if absent
  function automatic int find_first(key_t k);
    for (int unsigned i = 0; i < list_len; i++)
      if (list_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < list_len; i++) begin
      list_key[i] = list_key[i+1];
      list_pay[i] = list_pay[i+1];
    end
    list_len--;
  endfunction

  // goes after every entry with key <= k; caller makes sure there is room
  function automatic void place_sorted(key_t k, pay_t p);
    int unsigned pos;
    pos = 0;
    while (pos < list_len && list_key[pos] <= k) pos++;
    for (int unsigned i = list_len; i > pos; i--) begin
      list_key[i] = list_key[i-1];
      list_pay[i] = list_pay[i-1];
    end
    list_key[pos] = k;
    list_pay[pos] = p;
    list_len++;
  endfunction

  function automatic outcome_t apply_request(logic [1:0] func, key_t k, key_t nk, pay_t p);
    outcome_t    o;
    int unsigned lim;
    int          idx;
    o   = '0;
    lim = (cap_q > DEPTH) ? DEPTH : cap_q;
    case (func)
      FUNC_INSERT: begin
        if (list_len >= lim) o.status = STATUS_FULL;
        else place_sorted(k, p);
      end
      FUNC_REMOVE, FUNC_UPDATE: begin
        if (list_len == 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          idx = find_first(k);
          if (idx < 0) begin
            o.status = STATUS_NOTFOUND;
          end else begin
            o.pay = list_pay[idx];
            drop_at(idx);
            if (func == FUNC_UPDATE) place_sorted(nk, o.pay);
          end
        end
      end
      default: ;
    endcase
    o.count = 5'(list_len);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      list_len       = 0;
      cap_q          = CAP_RESET;
      awaited.delete();
      pending_o      = 0;
      mismatch_cnt_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) cap_q = cfg_data_i;
      // results first: a result never belongs to the request taken at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.pay    = m_axis_tdata[33:2];
        got.count  = m_axis_tdata[38:34];
        if (awaited.size() == 0) begin
          $error("result with no request outstanding, tdata %h", m_axis_tdata);
          mismatch_cnt_o++;
        end else begin
          want = awaited.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_cnt_o++;
          end
          if (got.pay !== want.pay) begin
            $error("payload_out: expected %h, got %h", want.pay, got.pay);
            mismatch_cnt_o++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            mismatch_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited.push_back(apply_request(s_axis_tuser, s_axis_tdata[63:0],
                                        s_axis_tdata[127:64], s_axis_tdata[159:128]));
      pending_o = awaited.size();
    end
  end

endmodule

// ===== verif/tb_sorted_key_list_unit.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_list_unit;
  import skl_pkg::*;

  // func code with no operation behind it; the block must still answer
  localparam logic [FUNC_WIDTH-1:0] FUNC_NOP = 2'd3;

  localparam int PHASES    = 10;
  localparam int PHASE_LEN = 100;
  localparam int POOL_SIZE = 10;

  // capacity per phase: the extremes 0, 1, 16, 31, values past DEPTH, and a
  // drop to 2 right after an insert-heavy phase so the list sits above it
  localparam logic [4:0] PHASE_CAP [PHASES] =
    '{5'd16, 5'd1, 5'd0, 5'd31, 5'd16, 5'd2, 5'd17, 5'd5, 5'd12, 5'd16};
  // share of inserts per phase, in percent
  localparam int PHASE_INS [PHASES] = '{80, 60, 50, 55, 85, 30, 60, 55, 50, 55};

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata  = '0;   // key, new_key, payload, zero fill (low bit first)
  logic [1:0]   s_axis_tuser  = '0;   // func
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;         // status, payload_out, count, zero fill
  logic         cfg_valid_i   = 1'b0;
  logic         cfg_ready_o;
  logic [4:0]   cfg_data_i    = '0;

  int   mismatches;
  int   pending;
  bit   quiet   = 1'b0;   // end of run: no stalls on either side
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;
  int   stall_left = 0;
  int   req_by_func [4] = '{0, 0, 0, 0};
  int   cap_writes = 0;
  key_t key_pool [POOL_SIZE];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sorted_key_list_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  skl_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Result side backpressure: random stalls, with calm stretches toggled at
  // random, and none at all once quiet is set.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 149) == 0) rx_calm = !rx_calm;
    if (quiet) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 12) begin
      stall_left = $urandom_range(0, 11);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one request and hold it until taken. tvalid stays high on exit so
  // a back-to-back request does not drop it in between.
  task automatic issue(input logic [1:0] func, input key_t k, input key_t nk, input pay_t p);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {8'h00, p, nk, k};
    s_axis_tuser  <= func;
    req_by_func[func]++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  // Stop sending and wait until every predicted result is back.
  task automatic drain();
    sender_gap(1);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // capacity is only written with the block idle
  task automatic set_capacity(input logic [4:0] c);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_writes++;
  endtask

  function automatic key_t rand_key();
    return {$urandom, $urandom};
  endfunction

  // mostly pool keys so removes and updates find something; some strays
  function automatic key_t pool_key(input int stray_pct);
    if ($urandom_range(0, 99) < stray_pct) return rand_key();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic pay_t rand_pay();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Keys 0 and all-ones always in the pool; a share of tiny keys makes
  // runs of equal keys, the rest spread over the whole 64-bit range.
  task automatic refill_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++)
      key_pool[i] = ($urandom_range(0, 9) < 3) ? key_t'($urandom_range(0, 3)) : rand_key();
  endtask

  task automatic random_request(input int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct)
      issue(FUNC_INSERT, pool_key(10), rand_key(), rand_pay());
    else if (r < ins_pct + (100 - ins_pct) * 55 / 100)
      issue(FUNC_REMOVE, pool_key(10), rand_key(), rand_pay());
    else if (r < 98)
      issue(FUNC_UPDATE, pool_key(10), pool_key(20), rand_pay());
    else
      issue(FUNC_NOP, rand_key(), rand_key(), rand_pay());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_capacity(CAP_RESET);

    // directed: empty list, no-op code, key and payload extremes, equal keys
    // leaving in arrival order, head removal, missing key, update onto the
    // same key and onto a key past every other
    issue(FUNC_REMOVE, 64'd7, '0, '0);
    issue(FUNC_UPDATE, 64'd7, 64'd8, '0);
    issue(FUNC_NOP, '0, '0, '0);
    issue(FUNC_INSERT, '0, '0, '0);
    issue(FUNC_INSERT, '1, '0, '1);
    issue(FUNC_INSERT, 64'd5, '0, 32'hAAAA_0001);
    issue(FUNC_INSERT, 64'd5, '0, 32'hAAAA_0002);
    issue(FUNC_INSERT, 64'd5, '0, 32'hAAAA_0003);
    issue(FUNC_REMOVE, 64'd5, '0, '0);
    issue(FUNC_REMOVE, 64'd9, '0, '0);
    issue(FUNC_UPDATE, 64'd5, '1, '0);
    issue(FUNC_UPDATE, '0, '0, '0);
    issue(FUNC_REMOVE, '1, '0, '0);
    issue(FUNC_REMOVE, '0, '0, '0);
    issue(FUNC_INSERT, 64'h8000_0000_0000_0000, '0, 32'h8000_0000);
    issue(FUNC_UPDATE, 64'd5, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    issue(FUNC_NOP, '1, '1, '1);
    issue(FUNC_INSERT, 64'd3, '1, 32'h5555_5555);
    issue(FUNC_INSERT, 64'd3, '0, 32'h0000_FFFF);
    issue(FUNC_REMOVE, '1, '0, '0);

    // random phases, one capacity each
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(PHASE_CAP[ph]);
      refill_pool();
      if (ph == PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_LEN; i++) begin
        tx_calm = ((i / 25) % 2) == 1;
        if (!quiet && !tx_calm && $urandom_range(0, 99) < 10)
          sender_gap($urandom_range(1, 12));
        // mid-phase hold-off: nothing new until the result queue is empty
        if (ph == 4 && i == PHASE_LEN / 2) drain();
        random_request(PHASE_INS[ph]);
      end
    end

    sender_gap(1);
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests: %0d insert, %0d remove, %0d update, %0d no-op.",
             req_by_func[FUNC_INSERT] + req_by_func[FUNC_REMOVE] +
             req_by_func[FUNC_UPDATE] + req_by_func[FUNC_NOP],
             req_by_func[FUNC_INSERT], req_by_func[FUNC_REMOVE],
             req_by_func[FUNC_UPDATE], req_by_func[FUNC_NOP]);
    $display("%0d capacity writes (0, 1, 2, 16, 17, 31 among them), %0d mismatches.",
             cap_writes, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/skl_pkg.sv
sv/skl_cell.sv
sv/skl_chain.sv
sv/sorted_key_list_unit.sv
sv/skl_checker.sv
verif/skl_checker.sv
verif/tb_sorted_key_list_unit.sv
